// ----- hdl/bec_pkg.sv -----
// ----------------------------------------------------------------------------
// bec_pkg
// Shared types and constants for the bounce easing curve pipeline.
// ----------------------------------------------------------------------------
package bec_pkg;

  // Curve selector codes carried on the func port.
  localparam logic [1:0] FUNC_OUT   = 2'd0;
  localparam logic [1:0] FUNC_IN    = 2'd1;
  localparam logic [1:0] FUNC_INOUT = 2'd2;

  // How the shape value b is turned into the Q31 factor f.
  typedef enum logic [1:0] {
    FM_OUT,       // f = 2*b
    FM_IN,        // f = 2*(1 - b)
    FM_INOUT_LO,  // f = 1 - b
    FM_INOUT_HI   // f = 1 + b
  } bec_fmode_t;

  // Parabola segment of the bounce shape.
  typedef enum logic [1:0] {
    SEG_0,
    SEG_1,
    SEG_2,
    SEG_3
  } bec_seg_t;

  // Q30 offsets k of the four segments: 0, 0.75, 0.9375 and 0.984375.
  localparam logic [30:0] K_SEG_0 = 31'd0;
  localparam logic [30:0] K_SEG_1 = 31'd3 << 28;
  localparam logic [30:0] K_SEG_2 = 31'd15 << 26;
  localparam logic [30:0] K_SEG_3 = 31'd63 << 24;

  // 1.0 in Q30.
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  // Interpolation data that travels next to the curve factor.
  typedef struct packed {
    logic [31:0] origin;  // start value, Q16.16 two's complement
    logic        neg;     // target below origin
    logic [32:0] dmag;    // |target - origin|
  } bec_side_t;

endpackage

// ----- hdl/bec_shape.sv -----
// ----------------------------------------------------------------------------
// bec_shape
// Five-stage pipeline from selector and progress to the Q31 curve factor.
// ----------------------------------------------------------------------------
module bec_shape #(
  parameter int P = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [1:0]  func,
  input  logic [15:0] progress,
  output logic        f_valid,
  output logic [31:0] f
);

  localparam int UW  = P + 1;
  localparam int CW  = (P + 2 > 16) ? P + 2 : 16;
  localparam int AW  = P + 5;
  localparam int MW  = P + 3;
  localparam int SW  = 2 * MW;
  localparam int XW  = 2 * P + 15;
  localparam int S   = 2 * P - 24;
  localparam int SR  = (S > 0) ? S : 0;
  localparam int SL  = (S < 0) ? -S : 0;
  localparam int SRH = (SR > 0) ? SR - 1 : 0;

  localparam logic [CW-1:0] ONE_T  = CW'(1) << P;
  localparam logic [AW-1:0] A_BRK1 = AW'(8) << P;
  localparam logic [AW-1:0] A_BRK2 = AW'(16) << P;
  localparam logic [AW-1:0] A_BRK3 = AW'(20) << P;
  localparam logic [XW-1:0] RND    = (SR > 0) ? (XW'(1) << SRH) : '0;

  // Stage 1: clamp progress and form the shape argument.
  logic [CW-1:0]       t_ext;
  logic [CW-1:0]       t_cl;
  logic [CW-1:0]       t2;
  logic [CW-1:0]       u_calc;
  bec_pkg::bec_fmode_t mode_calc;
  logic [UW-1:0]       u1;
  bec_pkg::bec_fmode_t mode1;
  logic                v1;

  always_comb begin
    t_ext = CW'(progress);
    t_cl  = (t_ext > ONE_T) ? ONE_T : t_ext;
    t2    = t_cl << 1;
    case (func)
      bec_pkg::FUNC_IN: begin
        u_calc    = ONE_T - t_cl;
        mode_calc = bec_pkg::FM_IN;
      end
      bec_pkg::FUNC_INOUT: begin
        if (t2 < ONE_T) begin
          u_calc    = ONE_T - t2;
          mode_calc = bec_pkg::FM_INOUT_LO;
        end else begin
          u_calc    = t2 - ONE_T;
          mode_calc = bec_pkg::FM_INOUT_HI;
        end
      end
      default: begin
        u_calc    = t_cl;
        mode_calc = bec_pkg::FM_OUT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    u1    <= UW'(u_calc);
    mode1 <= mode_calc;
  end

  // Stage 2: scale by 22 and find the segment.
  logic [AW-1:0]       a_calc;
  bec_pkg::bec_seg_t   seg_calc;
  logic [AW-1:0]       a2;
  bec_pkg::bec_seg_t   seg2;
  bec_pkg::bec_fmode_t mode2;
  logic                v2;

  always_comb begin
    a_calc = AW'(u1) * AW'(22);
    if (a_calc < A_BRK1) begin
      seg_calc = bec_pkg::SEG_0;
    end else if (a_calc < A_BRK2) begin
      seg_calc = bec_pkg::SEG_1;
    end else if (a_calc < A_BRK3) begin
      seg_calc = bec_pkg::SEG_2;
    end else begin
      seg_calc = bec_pkg::SEG_3;
    end
  end

  always_ff @(posedge clk) begin
    a2    <= a_calc;
    seg2  <= seg_calc;
    mode2 <= mode1;
  end

  // Stage 3: distance from the segment center, in units of 1/22.
  logic [AW-1:0]       c_calc;
  logic [AW-1:0]       d_calc;
  logic [MW-1:0]       mag3;
  bec_pkg::bec_seg_t   seg3;
  bec_pkg::bec_fmode_t mode3;
  logic                v3;

  always_comb begin
    unique case (seg2)
      bec_pkg::SEG_0: c_calc = '0;
      bec_pkg::SEG_1: c_calc = AW'(12) << P;
      bec_pkg::SEG_2: c_calc = AW'(18) << P;
      bec_pkg::SEG_3: c_calc = AW'(21) << P;
      default:        c_calc = '0;
    endcase
    d_calc = (a2 >= c_calc) ? (a2 - c_calc) : (c_calc - a2);
  end

  always_ff @(posedge clk) begin
    mag3  <= MW'(d_calc);
    seg3  <= seg2;
    mode3 <= mode2;
  end

  // Stage 4: square.
  logic [SW-1:0]       sq4;
  bec_pkg::bec_seg_t   seg4;
  bec_pkg::bec_fmode_t mode4;
  logic                v4;

  always_ff @(posedge clk) begin
    sq4   <= mag3 * mag3;
    seg4  <= seg3;
    mode4 <= mode3;
  end

  // Stage 5: round into Q30, add the segment offset and form the factor.
  logic [XW-1:0] term_x;
  logic [30:0]   k_calc;
  logic [30:0]   b_calc;
  logic [31:0]   f_calc;

  always_comb begin
    term_x = ((XW'(sq4) + RND) >> SR) << SL;
    unique case (seg4)
      bec_pkg::SEG_0: k_calc = bec_pkg::K_SEG_0;
      bec_pkg::SEG_1: k_calc = bec_pkg::K_SEG_1;
      bec_pkg::SEG_2: k_calc = bec_pkg::K_SEG_2;
      bec_pkg::SEG_3: k_calc = bec_pkg::K_SEG_3;
      default:        k_calc = bec_pkg::K_SEG_0;
    endcase
    b_calc = term_x[30:0] + k_calc;
    unique case (mode4)
      bec_pkg::FM_OUT:      f_calc = {b_calc, 1'b0};
      bec_pkg::FM_IN:       f_calc = (bec_pkg::ONE_Q30 - {1'b0, b_calc}) << 1;
      bec_pkg::FM_INOUT_LO: f_calc = bec_pkg::ONE_Q30 - {1'b0, b_calc};
      bec_pkg::FM_INOUT_HI: f_calc = bec_pkg::ONE_Q30 + {1'b0, b_calc};
      default:              f_calc = {b_calc, 1'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    f <= f_calc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      f_valid <= 1'b0;
    end else begin
      v1      <= in_valid;
      v2      <= v1;
      v3      <= v2;
      v4      <= v3;
      f_valid <= v4;
    end
  end

endmodule

// ----- hdl/bec_scale.sv -----
// ----------------------------------------------------------------------------
// bec_scale
// Three-stage pipeline that scales the difference by the factor, rounds,
// adds the origin and saturates.
// ----------------------------------------------------------------------------
module bec_scale (
  input  logic              clk,
  input  logic              rst,
  input  logic              f_valid,
  input  logic [31:0]       f,
  input  bec_pkg::bec_side_t side,
  output logic              done,
  output logic [31:0]       eased_value,
  output logic              saturated
);

  // Stage A: two partial products of |d| * f.
  logic [47:0] plo_a;
  logic [48:0] phi_a;
  logic [31:0] origin_a;
  logic        neg_a;
  logic        v_a;

  always_ff @(posedge clk) begin
    plo_a    <= side.dmag[15:0] * f;
    phi_a    <= side.dmag[32:16] * f;
    origin_a <= side.origin;
    neg_a    <= side.neg;
  end

  // Stage B: combine and round half away from zero at 2^-31.
  logic [63:0] sum_b;
  logic [32:0] prod_b;
  logic [31:0] origin_b;
  logic        neg_b;
  logic        v_b;

  assign sum_b = {phi_a[47:0], 16'd0} + {16'd0, plo_a} + (64'd1 << 30);

  always_ff @(posedge clk) begin
    prod_b   <= sum_b[63:31];
    origin_b <= origin_a;
    neg_b    <= neg_a;
  end

  // Stage C: apply the sign, add the origin and clip to 32 bits.
  logic [34:0] delta_c;
  logic [34:0] r_c;
  logic        over_c;

  always_comb begin
    delta_c = neg_b ? (35'd0 - {2'b00, prod_b}) : {2'b00, prod_b};
    r_c     = {{3{origin_b[31]}}, origin_b} + delta_c;
    over_c  = (r_c[34:31] != 4'b0000) && (r_c[34:31] != 4'b1111);
  end

  always_ff @(posedge clk) begin
    if (over_c) begin
      eased_value <= r_c[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      eased_value <= r_c[31:0];
    end
    saturated <= over_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a  <= 1'b0;
      v_b  <= 1'b0;
      done <= 1'b0;
    end else begin
      v_a  <= f_valid;
      v_b  <= v_a;
      done <= v_b;
    end
  end

endmodule

// ----- hdl/bounce_easing_curve.sv -----
// ----------------------------------------------------------------------------
// bounce_easing_curve
// Bounce easing interpolator: origin + (target - origin) * curve(progress),
// with ease-out, ease-in and ease-in-out bounce shapes, Q16.16 values and a
// saturation flag.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake        Payload
//   -------   --------------   -------------------------------------------
//   item in   start / busy     func, origin_value, target_value, progress
//   item out  done (strobe)    eased_value, saturated
//
// A new item can enter on every cycle, and each item passes through every
// stage below in turn, from the edge that accepts it to its done strobe.
// The depth is set by the shape pipeline (argument, segment, distance,
// square, factor) followed by the partial-product multiply stage, the
// combine and round stage and the final add and clip stage. Busy is always
// low since nothing in the pipeline ever waits, and the receiver takes each
// result in the cycle it appears. Reset clears only the valid bits; items in
// flight are dropped.
//
module bounce_easing_curve #(
  parameter int PROGRESS_FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [31:0] origin_value,
  input  logic [31:0] target_value,
  input  logic [15:0] progress,
  output logic        done,
  output logic [31:0] eased_value,
  output logic        saturated
);

  // The pipeline accepts an item on every cycle.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // The curve factor path.
  logic        f_valid;
  logic [31:0] f;

  bec_shape #(
    .P(PROGRESS_FRAC_BITS)
  ) u_shape (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .func     (func),
    .progress (progress),
    .f_valid  (f_valid),
    .f        (f)
  );

  // The difference path runs beside the shape pipeline so that origin and
  // |d| line up with the factor five stages later. The difference is taken
  // on 33 bits so that it never wraps.
  localparam int SIDE_DLY = 3;

  logic [32:0]        d1;
  logic [31:0]        origin1;
  bec_pkg::bec_side_t side2;
  bec_pkg::bec_side_t side_dly [SIDE_DLY];

  always_ff @(posedge clk) begin
    d1      <= {target_value[31], target_value} - {origin_value[31], origin_value};
    origin1 <= origin_value;
  end

  always_ff @(posedge clk) begin
    side2.origin <= origin1;
    side2.neg    <= d1[32];
    side2.dmag   <= d1[32] ? (33'd0 - d1) : d1;
  end

  always_ff @(posedge clk) begin
    side_dly[0] <= side2;
    for (int i = 1; i < SIDE_DLY; i++) begin
      side_dly[i] <= side_dly[i-1];
    end
  end

  // Scaling, rounding and clipping.
  bec_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .f_valid     (f_valid),
    .f           (f),
    .side        (side_dly[SIDE_DLY-1]),
    .done        (done),
    .eased_value (eased_value),
    .saturated   (saturated)
  );

endmodule

// ----- tb/sv/bec_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bec_checker
// Watches both channels of the bounce easing curve, predicts each eased value
// from the accepted item and compares it with the result that comes out.
// ----------------------------------------------------------------------------
module bec_checker #(
  parameter int PROGRESS_FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  func,
  input  logic [31:0] origin_value,
  input  logic [31:0] target_value,
  input  logic [15:0] progress,
  input  logic        done,
  input  logic [31:0] eased_value,
  input  logic        saturated,
  output int          mismatches,
  output int          outstanding
);

  localparam logic [63:0] T_ONE    = 64'd1 << PROGRESS_FRAC_BITS;
  localparam logic [63:0] UNIT_Q30 = 64'd1 << 30;
  localparam int          SQ_SHIFT = 2 * PROGRESS_FRAC_BITS - 24;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
    logic [1:0]  fn;
    logic [15:0] prog;
  } eased_result_t;

  eased_result_t eased_expected_q[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Bounce shape b(u) in Q30 for u = U / 2^P.
  function automatic logic [63:0] bounce_shape_q30(input logic [63:0] u);
    logic [63:0] m, k, a, c, mag, sq, term;
    if (11 * u < 4 * T_ONE) begin
      m = 0;
      k = 0;
    end else if (11 * u < 8 * T_ONE) begin
      m = 12;
      k = (UNIT_Q30 * 3) >> 2;
    end else if (11 * u < 10 * T_ONE) begin
      m = 18;
      k = (UNIT_Q30 * 15) >> 4;
    end else begin
      m = 21;
      k = (UNIT_Q30 * 63) >> 6;
    end
    a   = 22 * u;
    c   = m * T_ONE;
    mag = (a >= c) ? a - c : c - a;
    sq  = mag * mag;
    if (SQ_SHIFT > 0) begin
      term = (sq + (64'd1 << (SQ_SHIFT - 1))) >> SQ_SHIFT;
    end else begin
      term = sq << (-SQ_SHIFT);
    end
    return term + k;
  endfunction

  function automatic eased_result_t bounce_eased(input logic [1:0] fn,
                                                 input logic [31:0] org,
                                                 input logic [31:0] tgt,
                                                 input logic [15:0] prog);
    eased_result_t res;
    logic [63:0]   t, f, dmag, prod;
    longint        o, tv, d, r;
    t = prog;
    if (t > T_ONE) t = T_ONE;
    case (fn)
      bec_pkg::FUNC_IN: begin
        f = 2 * (UNIT_Q30 - bounce_shape_q30(T_ONE - t));
      end
      bec_pkg::FUNC_INOUT: begin
        if (2 * t < T_ONE) f = UNIT_Q30 - bounce_shape_q30(T_ONE - 2 * t);
        else f = UNIT_Q30 + bounce_shape_q30(2 * t - T_ONE);
      end
      default: begin
        f = 2 * bounce_shape_q30(t);
      end
    endcase
    o    = longint'($signed(org));
    tv   = longint'($signed(tgt));
    d    = tv - o;
    dmag = (d < 0) ? -d : d;
    prod = (dmag * f + (64'd1 << 30)) >> 31;
    r    = (d < 0) ? o - $signed(prod) : o + $signed(prod);
    res.sat = 1'b0;
    if (r > 64'sd2147483647) begin
      r = 64'sd2147483647;
      res.sat = 1'b1;
    end else if (r < -64'sd2147483648) begin
      r = -64'sd2147483648;
      res.sat = 1'b1;
    end
    res.value = r[31:0];
    res.fn    = fn;
    res.prog  = prog;
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Results are retired before new items are queued so a same-edge pair
  // never sees the fresh item.
  always @(posedge clk) begin
    eased_result_t exp_r;
    if (!rst) begin
      if (done) begin
        if (eased_expected_q.size() == 0) begin
          flag_mismatch($sformatf("result %h/%b with no item outstanding",
                                  eased_value, saturated));
        end else begin
          exp_r = eased_expected_q.pop_front();
          if (eased_value !== exp_r.value) begin
            flag_mismatch($sformatf("func %0d progress %0d: eased_value %h, want %h",
                                    exp_r.fn, exp_r.prog, eased_value, exp_r.value));
          end
          if (saturated !== exp_r.sat) begin
            flag_mismatch($sformatf("func %0d progress %0d: saturated %b, want %b",
                                    exp_r.fn, exp_r.prog, saturated, exp_r.sat));
          end
        end
      end
      if (start && !busy) begin
        eased_expected_q.push_back(bounce_eased(func, origin_value, target_value,
                                                progress));
      end
    end
    outstanding = eased_expected_q.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the bounce easing curve: directed corner items,
// then random items under three sender idle profiles, checked by bec_checker.
// ----------------------------------------------------------------------------
module tb;

  // The selector code that the block treats like ease-out.
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;

  // 1.0 in the Q1.15 progress format.
  localparam logic [15:0] T_FULL = 16'd32768;

  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;

  // Random items per idle profile; three profiles give about 1350 items.
  localparam int          ITEMS_PER_PHASE = 450;

  // The drain wait gives any stray result time to leave the pipeline.
  localparam int          DRAIN_CYCLES = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  func = bec_pkg::FUNC_OUT;
  logic [31:0] origin_value = '0;
  logic [31:0] target_value = '0;
  logic [15:0] progress = '0;
  logic        busy;
  logic        done;
  logic [31:0] eased_value;
  logic        saturated;
  int          mismatches;
  int          outstanding;

  bounce_easing_curve #(
    .PROGRESS_FRAC_BITS(15)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .origin_value(origin_value),
    .target_value(target_value),
    .progress    (progress),
    .done        (done),
    .eased_value (eased_value),
    .saturated   (saturated)
  );

  bec_checker #(
    .PROGRESS_FRAC_BITS(15)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .origin_value(origin_value),
    .target_value(target_value),
    .progress    (progress),
    .done        (done),
    .eased_value (eased_value),
    .saturated   (saturated),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs. A correct run needs roughly 6 us,
  // so this limit leaves a wide margin.
  initial begin
    #200us;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Presents one item and holds it until the block takes it. Before the
  // item the sender idles each cycle with the given chance in a hundred.
  // The caller is always standing on a rising edge, so start gets a single
  // update per step: it either stays high into the next item or drops for
  // a gap.
  task automatic drive_item(input logic [1:0] fn, input logic [31:0] org,
                            input logic [31:0] tgt, input logic [15:0] prog,
                            input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    func         <= fn;
    origin_value <= org;
    target_value <= tgt;
    progress     <= prog;
    do @(posedge clk); while (busy);
  endtask

  // A Q16.16 value: full random, small around zero, or one of the extremes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      default: begin
        case ($urandom_range(0, 3))
          0:       return Q_MIN;
          1:       return Q_MAX;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // Progress mostly inside [0, 1], with segment breakpoints, the half point
  // for in-out, and values past 1.0 that the block has to clamp.
  function automatic logic [15:0] pick_progress();
    int bp;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0:       bp = 11915;
          1:       bp = 23831;
          2:       bp = 29789;
          3:       bp = T_FULL - 11915;
          4:       bp = T_FULL - 23831;
          default: bp = T_FULL - 29789;
        endcase
        return 16'(bp + $urandom_range(0, 3) - 1);
      end
      1: begin
        case ($urandom_range(0, 2))
          0:       return 16'd0;
          1:       return T_FULL;
          default: return 16'((T_FULL / 2) - $urandom_range(0, 1));
        endcase
      end
      2:       return 16'($urandom_range(T_FULL + 1, 16'hFFFF));
      default: return 16'($urandom_range(0, T_FULL));
    endcase
  endfunction

  task automatic run_random(input int count, input int idle_pct);
    logic [1:0]  fn;
    logic [31:0] org;
    logic [31:0] tgt;
    int          sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 15);
      if (sel == 15) fn = FUNC_UNUSED;
      else if (sel % 3 == 0) fn = bec_pkg::FUNC_OUT;
      else if (sel % 3 == 1) fn = bec_pkg::FUNC_IN;
      else fn = bec_pkg::FUNC_INOUT;
      org = pick_value();
      // Now and then the target sits on or right next to the origin, so the
      // rounding of very small distances gets exercised.
      case ($urandom_range(0, 7))
        0:       tgt = org;
        1:       tgt = org + $urandom_range(0, 8) - 4;
        default: tgt = pick_value();
      endcase
      drive_item(fn, org, tgt, pick_progress(), idle_pct);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Full-range swings at both ends of time; the ease-in-out case sits on
    // either side of its half point.
    drive_item(bec_pkg::FUNC_OUT,   Q_MIN, Q_MAX, T_FULL, 16);
    drive_item(bec_pkg::FUNC_OUT,   Q_MAX, Q_MIN, 16'd0, 16);
    drive_item(bec_pkg::FUNC_IN,    Q_MIN, Q_MAX, 16'd0, 16);
    drive_item(bec_pkg::FUNC_IN,    Q_MAX, Q_MIN, T_FULL, 16);
    drive_item(bec_pkg::FUNC_INOUT, Q_MIN, Q_MAX, T_FULL / 2, 16);
    drive_item(bec_pkg::FUNC_INOUT, Q_MAX, Q_MIN, T_FULL / 2 - 1, 16);
    drive_item(bec_pkg::FUNC_INOUT, Q_MIN, Q_MAX, T_FULL / 4, 16);

    // Each side of the three breakpoints of the bounce shape for ease-out, and
    // each side of the first one for ease-in through the mirrored argument.
    drive_item(bec_pkg::FUNC_OUT,   32'h0, 32'h0001_0000, 16'd11915, 16);
    drive_item(bec_pkg::FUNC_OUT,   32'h0, 32'h0001_0000, 16'd11916, 16);
    drive_item(bec_pkg::FUNC_OUT,   32'h0, 32'h0001_0000, 16'd23831, 16);
    drive_item(bec_pkg::FUNC_OUT,   32'h0, 32'h0001_0000, 16'd23832, 16);
    drive_item(bec_pkg::FUNC_OUT,   32'h0, 32'h0001_0000, 16'd29789, 16);
    drive_item(bec_pkg::FUNC_OUT,   32'h0, 32'h0001_0000, 16'd29790, 16);
    drive_item(bec_pkg::FUNC_IN,    32'h0, 32'h0100_0000, 16'd20853, 16);
    drive_item(bec_pkg::FUNC_IN,    32'h0, 32'h0100_0000, 16'd20852, 16);

    // Progress past 1.0 must act as exactly 1.0.
    drive_item(bec_pkg::FUNC_OUT,   32'hFFFB_0000, 32'h0007_0000, 16'hFFFF, 16);
    drive_item(bec_pkg::FUNC_IN,    32'hFFFB_0000, 32'h0007_0000, T_FULL + 1, 16);
    drive_item(bec_pkg::FUNC_INOUT, Q_MAX, Q_MIN, 16'hFFFF, 16);

    // The unused selector code falls back to ease-out.
    drive_item(FUNC_UNUSED, 32'hFFFB_0000, 32'h0007_0000, 16'd12000, 16);
    drive_item(FUNC_UNUSED, Q_MAX, Q_MIN, 16'hFFFF, 16);

    // Zero distance, and a two-LSB distance where only rounding matters.
    drive_item(bec_pkg::FUNC_OUT,   32'h1234_5678, 32'h1234_5678, 16'd20000, 16);
    drive_item(bec_pkg::FUNC_OUT,   32'hFFFF_FFFF, 32'h0000_0001, 16'd1, 16);
    drive_item(bec_pkg::FUNC_INOUT, Q_MIN, Q_MIN, T_FULL, 16);

    // Random items: light sender gaps, heavy gaps, then back to back.
    run_random(ITEMS_PER_PHASE, 16);
    run_random(ITEMS_PER_PHASE, 75);
    run_random(ITEMS_PER_PHASE, 0);

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // Let any stray result that is still in the pipeline show up.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
